[rtl/blz_pkg.sv]
// Shared types and constants for the backward LZ77 decoder.
package blz_pkg;

  localparam int unsigned MIN_MATCH  = 3;
  localparam int unsigned DIST_BIAS  = 3;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned DIST_W     = 13;
  localparam int unsigned PLEN_W     = 24;
  localparam int unsigned CAP_W      = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_BAD_REF   = 2'd2,
    ST_TRUNCATED = 2'd3
  } blz_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_COPY
  } blz_state_t;

  // controller -> datapath
  typedef struct packed {
    logic        latch_in;
    logic        consume;
    logic        load_flag;
    logic        store_hi;
    logic        clear_pend;
    logic        start_copy;
    logic        emit_lit;
    logic        emit_copy;
    logic        rd_en;
    logic        bump_idx;
    logic        fail;
    blz_status_t fail_status;
  } blz_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ignore;
    logic pending;
    logic flag_needed;
    logic flag_bit_set;
    logic avail_one;
    logic full;
    logic copy_ovf;
    logic bad_ref;
    logic byte_top;
    logic cnt_last;
    logic out_free;
  } blz_flags_t;

endpackage

[rtl/blz_datapath.sv]
// Datapath of the backward LZ77 decoder: stream state, history memory, result register.
module blz_datapath #(
  parameter int unsigned HISTORY_DEPTH = 8192
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [7:0]                   in_byte,
  input  logic [blz_pkg::PLEN_W-1:0]   payload_length,
  input  logic [blz_pkg::CAP_W-1:0]    output_capacity,
  input  blz_pkg::blz_cmd_t            cmd,
  output blz_pkg::blz_flags_t          flags,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [7:0]                   out_byte_value,
  output logic                         out_byte_valid,
  output logic                         out_last_of_run,
  output logic                         out_stream_done,
  output logic [1:0]                   out_status
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

  logic [7:0] hist_mem [HISTORY_DEPTH];

  logic [7:0]                   in_byte_r;
  logic [7:0]                   flag_bits_r;
  logic [3:0]                   idx_r;
  logic [7:0]                   hi_r;
  logic                         pend_r;
  logic [blz_pkg::PLEN_W-1:0]   consumed_r;
  logic [blz_pkg::CAP_W-1:0]    produced_r;
  logic [AW-1:0]                wr_r;
  logic [AW-1:0]                rd_ptr_r;
  logic [blz_pkg::LEN_W-1:0]    cnt_r;
  logic                         done_r;
  logic                         over_r;
  logic [7:0]                   rdata_r;

  logic                         ov_valid_r;
  logic [7:0]                   ov_value_r;
  logic                         ov_bvalid_r;
  logic                         ov_last_r;
  logic                         ov_done_r;
  blz_pkg::blz_status_t         ov_status_r;

  logic [blz_pkg::DIST_W-1:0]   tok_dist;
  logic [blz_pkg::LEN_W-1:0]    len;
  logic [blz_pkg::CAP_W:0]      end_sum;
  logic [AW:0]                  start_sum;
  logic [AW-1:0]                start_addr;
  logic [AW-1:0]                rd_ptr_inc;
  logic [AW-1:0]                wr_inc;
  logic                         emit;
  logic                         out_load;
  logic                         finish;

  assign tok_dist = blz_pkg::DIST_W'({hi_r[3:0], in_byte_r}) +
                    blz_pkg::DIST_W'(blz_pkg::DIST_BIAS);
  assign len  = blz_pkg::LEN_W'(hi_r[7:4]) + blz_pkg::LEN_W'(blz_pkg::MIN_MATCH);
  assign end_sum   = {1'b0, produced_r} + (blz_pkg::CAP_W+1)'(len);
  assign start_sum = {1'b0, wr_r} + DEPTH_EXT - (AW+1)'(tok_dist);
  assign start_addr = (start_sum >= DEPTH_EXT) ? AW'(start_sum - DEPTH_EXT) : AW'(start_sum);
  assign rd_ptr_inc = (rd_ptr_r == LAST_ADDR) ? '0 : rd_ptr_r + AW'(1);
  assign wr_inc     = (wr_r == LAST_ADDR) ? '0 : wr_r + AW'(1);

  always_comb begin
    flags.ignore       = over_r || (consumed_r >= payload_length);
    flags.pending      = pend_r;
    flags.flag_needed  = idx_r[3];
    flags.flag_bit_set = flag_bits_r[3'(3'd7 - idx_r[2:0])];
    flags.avail_one    = (consumed_r + blz_pkg::PLEN_W'(1)) == payload_length;
    flags.full         = produced_r == output_capacity;
    flags.copy_ovf     = (produced_r <= output_capacity) &&
                         (end_sum > {1'b0, output_capacity});
    flags.bad_ref      = {{(blz_pkg::CAP_W-blz_pkg::DIST_W){1'b0}}, tok_dist} > produced_r;
    flags.byte_top     = in_byte_r[7];
    flags.cnt_last     = cnt_r == blz_pkg::LEN_W'(1);
    flags.out_free     = !ov_valid_r || out_ready;
  end

  assign emit     = cmd.emit_lit || cmd.emit_copy;
  assign out_load = emit || cmd.fail;
  assign finish   = (cmd.emit_lit || cmd.start_copy) && flags.avail_one;

  // history memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (emit) begin
      hist_mem[wr_r] <= cmd.emit_lit ? in_byte_r : rdata_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= hist_mem[rd_ptr_r];
    end
    if (cmd.latch_in) begin
      in_byte_r <= in_byte;
    end
    if (cmd.start_copy) begin
      rd_ptr_r <= start_addr;
    end else if (cmd.rd_en) begin
      rd_ptr_r <= rd_ptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_bits_r <= '0;
      idx_r       <= 4'd8;
      hi_r        <= '0;
      pend_r      <= 1'b0;
      consumed_r  <= '0;
      produced_r  <= '0;
      wr_r        <= '0;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      over_r      <= 1'b0;
    end else begin
      if (cmd.consume) begin
        consumed_r <= consumed_r + blz_pkg::PLEN_W'(1);
      end
      if (cmd.load_flag) begin
        flag_bits_r <= in_byte_r;
        idx_r       <= '0;
      end else if (cmd.bump_idx) begin
        idx_r <= idx_r + 4'd1;
      end
      if (cmd.store_hi) begin
        hi_r   <= in_byte_r;
        pend_r <= 1'b1;
      end else if (cmd.clear_pend) begin
        pend_r <= 1'b0;
      end
      if (cmd.start_copy) begin
        cnt_r  <= len;
        done_r <= flags.avail_one;
      end else if (cmd.emit_copy) begin
        cnt_r <= cnt_r - blz_pkg::LEN_W'(1);
      end
      if (emit) begin
        wr_r       <= wr_inc;
        produced_r <= produced_r + blz_pkg::CAP_W'(1);
      end
      if (cmd.fail || finish) begin
        over_r <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_valid_r <= 1'b0;
    end else if (out_load) begin
      ov_valid_r <= 1'b1;
    end else if (out_ready) begin
      ov_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fail) begin
      ov_value_r  <= '0;
      ov_bvalid_r <= 1'b0;
      ov_last_r   <= 1'b1;
      ov_done_r   <= 1'b1;
      ov_status_r <= cmd.fail_status;
    end else if (cmd.emit_lit) begin
      ov_value_r  <= in_byte_r;
      ov_bvalid_r <= 1'b1;
      ov_last_r   <= 1'b1;
      ov_done_r   <= flags.avail_one;
      ov_status_r <= blz_pkg::ST_OK;
    end else if (cmd.emit_copy) begin
      ov_value_r  <= rdata_r;
      ov_bvalid_r <= 1'b1;
      ov_last_r   <= flags.cnt_last;
      ov_done_r   <= flags.cnt_last && done_r;
      ov_status_r <= blz_pkg::ST_OK;
    end
  end

  assign out_valid       = ov_valid_r;
  assign out_byte_value  = ov_value_r;
  assign out_byte_valid  = ov_bvalid_r;
  assign out_last_of_run = ov_last_r;
  assign out_stream_done = ov_done_r;
  assign out_status      = ov_status_r;

endmodule

[rtl/blz_ctrl.sv]
// Control state machine of the backward LZ77 decoder.
module blz_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  blz_pkg::blz_flags_t flags,
  output blz_pkg::blz_cmd_t   cmd
);

  blz_pkg::blz_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= blz_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.fail_status = blz_pkg::ST_OK;
    in_ready        = 1'b0;
    case (state_r)
      blz_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = blz_pkg::S_EXEC;
        end
      end
      blz_pkg::S_EXEC: begin
        // act only once the result register can take a transfer
        if (flags.out_free) begin
          state_nxt = blz_pkg::S_IDLE;
          if (!flags.ignore) begin
            cmd.consume = 1'b1;
            if (flags.pending) begin
              cmd.clear_pend = 1'b1;
              if (flags.copy_ovf) begin
                cmd.fail        = 1'b1;
                cmd.fail_status = blz_pkg::ST_OVERFLOW;
              end else if (flags.bad_ref) begin
                cmd.fail        = 1'b1;
                cmd.fail_status = blz_pkg::ST_BAD_REF;
              end else begin
                cmd.start_copy = 1'b1;
                cmd.bump_idx   = 1'b1;
                state_nxt      = blz_pkg::S_READ;
              end
            end else if (flags.flag_needed) begin
              cmd.load_flag = 1'b1;
              if (flags.avail_one) begin
                cmd.fail        = 1'b1;
                cmd.fail_status = (!flags.byte_top && flags.full) ?
                                  blz_pkg::ST_OVERFLOW : blz_pkg::ST_TRUNCATED;
              end
            end else if (flags.flag_bit_set) begin
              if (flags.avail_one) begin
                cmd.fail        = 1'b1;
                cmd.fail_status = blz_pkg::ST_TRUNCATED;
              end else begin
                cmd.store_hi = 1'b1;
              end
            end else if (flags.full) begin
              cmd.fail        = 1'b1;
              cmd.fail_status = blz_pkg::ST_OVERFLOW;
            end else begin
              cmd.emit_lit = 1'b1;
              cmd.bump_idx = 1'b1;
            end
          end
        end
      end
      blz_pkg::S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = blz_pkg::S_COPY;
      end
      blz_pkg::S_COPY: begin
        // hold the fetched byte while the receiver stalls
        if (flags.out_free) begin
          cmd.emit_copy = 1'b1;
          if (flags.cnt_last) begin
            state_nxt = blz_pkg::S_IDLE;
          end else begin
            cmd.rd_en = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = blz_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/backward_lz77_decoder.sv]
// Top level of the backward LZ77 decoder: register port, controller and datapath.
//
// Usage: program payload_length (offset 0x0) and output_capacity (offset 0x4)
// through the register port, then send the compressed payload one byte per
// transfer on the in_ channel, last byte first. Decoded bytes leave on the
// out_ channel in reverse order, one result per transfer; the last result of
// each input byte carries last_of_run, and the final result of the stream
// carries stream_done with its status (zero on success, else an error code,
// with byte_valid low).
// Timing: an input byte is taken in S_IDLE and decoded in S_EXEC, which
// waits while the result register holds an unread result. A flag byte, a
// token high byte or a literal needs only these states. A token low byte adds
// one history read in S_READ and then copies in S_COPY; the single history
// read port sets the copy rate, one byte per cycle unless the receiver stalls.
// Reset clears all stream state and the result valid flag; history contents
// need no clearing. A stalled receiver holds the result register and the
// decoder waits; the next input byte is still taken while a result waits.
// After the stream ends, further input bytes are taken and dropped.
module backward_lz77_decoder #(
  parameter int unsigned HISTORY_DEPTH = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_payload_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_value,
  output logic        out_byte_valid,
  output logic        out_last_of_run,
  output logic        out_stream_done,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_PAYLOAD_LENGTH  = 1'b0;
  localparam logic REG_OUTPUT_CAPACITY = 1'b1;

  logic [blz_pkg::PLEN_W-1:0] payload_length_r;
  logic [blz_pkg::CAP_W-1:0]  output_capacity_r;
  logic                       reg_wr;

  blz_pkg::blz_cmd_t   cmd;
  blz_pkg::blz_flags_t flags;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_length_r  <= '0;
      output_capacity_r <= '0;
    end else if (reg_wr) begin
      case (paddr[2])
        REG_PAYLOAD_LENGTH:  payload_length_r  <= pwdata[blz_pkg::PLEN_W-1:0];
        REG_OUTPUT_CAPACITY: output_capacity_r <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PAYLOAD_LENGTH:  prdata = {{(32-blz_pkg::PLEN_W){1'b0}}, payload_length_r};
      REG_OUTPUT_CAPACITY: prdata = output_capacity_r;
      default:             prdata = '0;
    endcase
  end

  blz_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .flags    (flags),
    .cmd      (cmd)
  );

  blz_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_byte         (in_payload_byte),
    .payload_length  (payload_length_r),
    .output_capacity (output_capacity_r),
    .cmd             (cmd),
    .flags           (flags),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_byte_value  (out_byte_value),
    .out_byte_valid  (out_byte_valid),
    .out_last_of_run (out_last_of_run),
    .out_stream_done (out_stream_done),
    .out_status      (out_status)
  );

endmodule
